### rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg: shared constants for the 3x3 matrix inverse
// Entry count, cofactor operand indexes and the result flag positions.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int NUM_ENT = 9;
	localparam int NUM_DET = 3;

	// Flag positions in the result tuser.
	localparam int USER_W         = 2;
	localparam int USER_SINGULAR  = 0;
	localparam int USER_SATURATED = 1;

	// Cofactor i is e[a]*e[b] - e[c]*e[d], entries in row-major order.
	localparam logic [3:0] CF_IDX [NUM_ENT][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7},
		'{4'd2, 4'd7, 4'd1, 4'd8},
		'{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8},
		'{4'd0, 4'd8, 4'd2, 4'd6},
		'{4'd3, 4'd2, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd6, 4'd4},
		'{4'd6, 4'd1, 4'd0, 4'd7},
		'{4'd0, 4'd4, 4'd3, 4'd1}
	};

	// Cofactors of the first row used by the determinant expansion.
	localparam logic [3:0] DET_CF [NUM_DET] = '{4'd0, 4'd3, 4'd6};

endpackage

### rtl/matrix_inverse_3x3.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: pipelined 3x3 inverse by adjugate, fixed point
// The input word carries the nine entries a_r0c0 .. a_r2c2; the output word
// carries the nine inverse entries and the singular and saturated flags.
//
// The slave channel takes one matrix per word and the master channel gives
// one inverse per word. Both are tvalid/tready streams; a word moves at a
// clock edge where tvalid and tready are both high. With no stall one matrix
// is taken every cycle. The pipeline has five stages of products, cofactors,
// determinant and rounded numerators, DATA_WIDTH + 1 restoring division
// stages that produce one quotient bit each, and the output register.
// Each entry is the cofactor divided by the determinant, rounded to nearest
// with ties away from zero and clipped to the signed range. A zero
// determinant gives all zero entries with singular set.
// When the receiver holds m_tready low while a result waits, the whole
// pipeline holds and s_tready falls in the same cycle; nothing is lost or
// repeated. Reset clears every stage valid bit, so the pipeline comes out
// of reset empty with m_tvalid low.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// Fields from bit 0 up: a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
	// a_r2c0, a_r2c1, a_r2c2, each DATA_WIDTH bits; zero pad to a byte.
	input  logic [((mi3_pkg::NUM_ENT*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// Fields from bit 0 up: inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
	// inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, each DATA_WIDTH bits; zero pad.
	output logic [((mi3_pkg::NUM_ENT*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	// Fields from bit 0 up: singular, saturated.
	output logic [mi3_pkg::USER_W-1:0] m_tuser
);
	import mi3_pkg::*;

	localparam int DW    = DATA_WIDTH;
	localparam int F     = FRAC_BITS;
	localparam int BUSW  = ((NUM_ENT*DW+7)/8)*8;
	localparam int CW    = 2*DW + 1;
	localparam int PW    = 2*DW + 1;
	localparam int DTW   = 3*DW + 3;
	localparam int NA    = CW + 2*F + 2;
	localparam int NB    = DTW + DW + 2;
	localparam int RW    = (NA > NB) ? NA : NB;
	localparam int QW    = DW + 1;
	localparam int NSTEP = DW + 1;

	logic adv;

	assign adv      = ~m_tvalid | m_tready;
	assign s_tready = adv;

	// Stage 1: the eighteen pairwise products.
	logic signed [DW-1:0]   ent_in [NUM_ENT];
	logic signed [2*DW-1:0] prod_s1 [NUM_ENT][2];
	logic signed [DW-1:0]   ent_s1 [NUM_DET];
	logic                   vld_s1;

	always_comb begin
		for (int j = 0; j < NUM_ENT; j++) begin
			ent_in[j] = $signed(s_tdata[j*DW +: DW]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NUM_ENT; i++) begin
				prod_s1[i][0] <= ent_in[CF_IDX[i][0]] * ent_in[CF_IDX[i][1]];
				prod_s1[i][1] <= ent_in[CF_IDX[i][2]] * ent_in[CF_IDX[i][3]];
			end
			for (int k = 0; k < NUM_DET; k++) begin
				ent_s1[k] <= ent_in[k];
			end
		end
	end

	// Stage 2: cofactors.
	logic signed [CW-1:0] cof_s2 [NUM_ENT];
	logic signed [DW-1:0] ent_s2 [NUM_DET];
	logic                 vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NUM_ENT; i++) begin
				cof_s2[i] <= CW'(prod_s1[i][0]) - CW'(prod_s1[i][1]);
			end
			for (int k = 0; k < NUM_DET; k++) begin
				ent_s2[k] <= ent_s1[k];
			end
		end
	end

	// Stage 3: determinant terms, each cofactor split into a signed high
	// half and an unsigned low half so every multiplier stays entry-wide.
	logic signed [PW-1:0] plo_s3 [NUM_DET];
	logic signed [PW-1:0] phi_s3 [NUM_DET];
	logic signed [CW-1:0] cof_s3 [NUM_ENT];
	logic                 vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_DET; k++) begin
				plo_s3[k] <= ent_s2[k] * $signed({1'b0, cof_s2[DET_CF[k]][DW-1:0]});
				phi_s3[k] <= ent_s2[k] * $signed(cof_s2[DET_CF[k]][CW-1:DW]);
			end
			for (int i = 0; i < NUM_ENT; i++) begin
				cof_s3[i] <= cof_s2[i];
			end
		end
	end

	// Stage 4: determinant sum.
	logic signed [DTW-1:0] det_sum;
	logic signed [DTW-1:0] det_s4;
	logic signed [CW-1:0]  cof_s4 [NUM_ENT];
	logic                  vld_s4;

	always_comb begin
		det_sum = '0;
		for (int k = 0; k < NUM_DET; k++) begin
			det_sum = det_sum + (DTW'(phi_s3[k]) <<< DW) + DTW'(plo_s3[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s4 <= det_sum;
			for (int i = 0; i < NUM_ENT; i++) begin
				cof_s4[i] <= cof_s3[i];
			end
		end
	end

	// Stage 5: magnitudes and rounded numerators 2|C|*2^(2F) + |D|.
	logic [DTW-1:0] det_abs;
	logic [CW-1:0]  cof_abs [NUM_ENT];
	logic [RW-1:0]  num_s5 [NUM_ENT];
	logic [DTW:0]   den_s5;
	logic           neg_s5 [NUM_ENT];
	logic           sing_s5;
	logic           vld_s5;

	always_comb begin
		det_abs = det_s4[DTW-1] ? $unsigned(-det_s4) : $unsigned(det_s4);
		for (int i = 0; i < NUM_ENT; i++) begin
			cof_abs[i] = cof_s4[i][CW-1] ? $unsigned(-cof_s4[i]) : $unsigned(cof_s4[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s5  <= {det_abs, 1'b0};
			sing_s5 <= (det_s4 == '0);
			for (int i = 0; i < NUM_ENT; i++) begin
				num_s5[i] <= (RW'(cof_abs[i]) << (2*F + 1)) + RW'(det_abs);
				neg_s5[i] <= cof_s4[i][CW-1] ^ det_s4[DTW-1];
			end
		end
	end

	// Stages 6 onward: restoring division, one quotient bit per stage from
	// bit DATA_WIDTH down to bit 0. A set top bit means the quotient is out
	// of range, whatever the lower bits say.
	logic [RW-1:0]  rem_s6  [NSTEP][NUM_ENT];
	logic [QW-1:0]  quo_s6  [NSTEP][NUM_ENT];
	logic           neg_s6  [NSTEP][NUM_ENT];
	logic [DTW:0]   den_s6  [NSTEP];
	logic           sing_s6 [NSTEP];
	logic           vld_s6  [NSTEP];

	for (genvar k = 0; k < NSTEP; k++) begin : g_div
		logic [RW-1:0] rem_in [NUM_ENT];
		logic [QW-1:0] quo_in [NUM_ENT];
		logic          neg_in [NUM_ENT];
		logic [DTW:0]  den_in;
		logic          sing_in;
		logic          vld_in;
		logic [RW-1:0] den_sh;

		if (k == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < NUM_ENT; i++) begin
					rem_in[i] = num_s5[i];
					quo_in[i] = '0;
					neg_in[i] = neg_s5[i];
				end
				den_in  = den_s5;
				sing_in = sing_s5;
				vld_in  = vld_s5;
			end
		end else begin : g_next
			always_comb begin
				for (int i = 0; i < NUM_ENT; i++) begin
					rem_in[i] = rem_s6[k-1][i];
					quo_in[i] = quo_s6[k-1][i];
					neg_in[i] = neg_s6[k-1][i];
				end
				den_in  = den_s6[k-1];
				sing_in = sing_s6[k-1];
				vld_in  = vld_s6[k-1];
			end
		end

		assign den_sh = RW'(den_in) << (DW - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s6[k] <= 1'b0;
			end else if (adv) begin
				vld_s6[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				den_s6[k]  <= den_in;
				sing_s6[k] <= sing_in;
				for (int i = 0; i < NUM_ENT; i++) begin
					neg_s6[k][i] <= neg_in[i];
					if (rem_in[i] >= den_sh) begin
						rem_s6[k][i] <= rem_in[i] - den_sh;
						quo_s6[k][i] <= {quo_in[i][QW-2:0], 1'b1};
					end else begin
						rem_s6[k][i] <= rem_in[i];
						quo_s6[k][i] <= {quo_in[i][QW-2:0], 1'b0};
					end
				end
			end
		end
	end

	// Output register: sign, clipping and the singular case.
	localparam int L = NSTEP - 1;

	logic [BUSW-1:0]   dat_next;
	logic              sat_next;
	logic [QW-1:0]     quo_fin;
	logic [DW-1:0]     mag;
	logic              clip;
	logic [BUSW-1:0]   dat_out_q;
	logic [USER_W-1:0] usr_out_q;
	logic              vld_out_q;

	always_comb begin
		dat_next = '0;
		sat_next = 1'b0;
		quo_fin  = '0;
		mag      = '0;
		clip     = 1'b0;
		for (int i = 0; i < NUM_ENT; i++) begin
			quo_fin = quo_s6[L][i];
			mag     = quo_fin[DW-1:0];
			if (neg_s6[L][i]) begin
				// The most negative value is reachable, so only beyond it clips.
				clip = quo_fin[DW] | (mag[DW-1] & (|mag[DW-2:0]));
				dat_next[i*DW +: DW] = clip ? {1'b1, {(DW-1){1'b0}}} : DW'(-mag);
			end else begin
				clip = quo_fin[DW] | mag[DW-1];
				dat_next[i*DW +: DW] = clip ? {1'b0, {(DW-1){1'b1}}} : mag;
			end
			sat_next = sat_next | clip;
		end
		if (sing_s6[L]) begin
			dat_next = '0;
			sat_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else if (adv) begin
			vld_out_q <= vld_s6[L];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dat_out_q                 <= dat_next;
			usr_out_q[USER_SINGULAR]  <= sing_s6[L];
			usr_out_q[USER_SATURATED] <= sat_next;
		end
	end

	assign m_tvalid = vld_out_q;
	assign m_tdata  = dat_out_q;
	assign m_tuser  = usr_out_q;

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for matrix_inverse_3x3
// Streams directed and random 3x3 Q16.16 matrices through the block and
// checks every inverse word against an exact wide-integer prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	import mi3_pkg::*;

	localparam int DW     = 32;
	localparam int FB     = 16;
	localparam int TDW    = ((NUM_ENT*DW+7)/8)*8;
	localparam int LIMIT  = 400000;
	localparam int HOLD   = 300;
	localparam logic [DW-1:0] ONE  = 32'h0001_0000;
	localparam logic [DW-1:0] MAXP = 32'h7FFF_FFFF;
	localparam logic [DW-1:0] MAXN = 32'h8000_0000;

	typedef struct packed {
		logic [TDW-1:0]    entries;
		logic [USER_W-1:0] flags;
	} inverse_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TDW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDW-1:0] m_tdata;
	logic [USER_W-1:0] m_tuser;

	logic [TDW-1:0] matrix_q[$];
	inverse_t inverse_q[$];
	int sent_cnt = 0;
	int hold_cnt = 0;
	int errors = 0;
	int cycles = 0;
	bit hold_done = 1'b0;

	matrix_inverse_3x3 #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Exact inverse: cofactors and determinant in wide integers, then a
	// rounded quotient with ties away from zero and clipping to the range.
	function automatic inverse_t invert_matrix(logic [TDW-1:0] m);
		logic signed [159:0] e[NUM_ENT];
		logic signed [159:0] cf[NUM_ENT];
		logic signed [159:0] det;
		logic [159:0] num, den, quo;
		logic neg;
		inverse_t r;
		r = '0;
		for (int i = 0; i < NUM_ENT; i++)
			e[i] = $signed(m[i*DW +: DW]);
		for (int i = 0; i < NUM_ENT; i++)
			cf[i] = e[CF_IDX[i][0]] * e[CF_IDX[i][1]] - e[CF_IDX[i][2]] * e[CF_IDX[i][3]];
		det = e[0] * cf[0] + e[1] * cf[3] + e[2] * cf[6];
		if (det == 0) begin
			r.flags[USER_SINGULAR] = 1'b1;
			return r;
		end
		den = (det < 0) ? -det : det;
		for (int i = 0; i < NUM_ENT; i++) begin
			neg = (cf[i] < 0) != (det < 0);
			num = ((cf[i] < 0) ? -cf[i] : cf[i]) << (2*FB + 1);
			quo = (num + den) / (den << 1);
			if (!neg && quo >= 160'h8000_0000) begin
				r.entries[i*DW +: DW] = MAXP;
				r.flags[USER_SATURATED] = 1'b1;
			end else if (neg && quo > 160'h8000_0000) begin
				r.entries[i*DW +: DW] = MAXN;
				r.flags[USER_SATURATED] = 1'b1;
			end else begin
				r.entries[i*DW +: DW] = neg ? -quo[DW-1:0] : quo[DW-1:0];
			end
		end
		return r;
	endfunction

	function automatic logic [TDW-1:0] pack_rows(logic [DW-1:0] a0, a1, a2, b0, b1, b2,
			c0, c1, c2);
		return TDW'({c2, c1, c0, b2, b1, b0, a2, a1, a0});
	endfunction

	function automatic logic [TDW-1:0] random_matrix();
		logic [TDW-1:0] m;
		int kind;
		m = '0;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < NUM_ENT; i++) begin
			case (kind)
				0, 1, 2, 3, 4, 5: m[i*DW +: DW] = $urandom_range(0, 32'h7FFFF) - 32'h40000;
				6, 7:             m[i*DW +: DW] = $urandom;
				default:          m[i*DW +: DW] = $urandom_range(0, 32'h3FF) - 32'h200;
			endcase
		end
		// A well-conditioned matrix gets a heavy diagonal now and then.
		if (kind < 3)
			for (int i = 0; i < 3; i++)
				m[(4*i)*DW +: DW] = m[(4*i)*DW +: DW] + 32'h0008_0000;
		// Copying row 0 into row 2 makes it singular.
		if (kind == 8)
			m[6*DW +: 3*DW] = m[0 +: 3*DW];
		return m;
	endfunction

	function automatic int sender_idle_pct();
		if (sent_cnt < 175) return 29;
		if (sent_cnt < 350) return 87;
		return 0;
	endfunction

	// Sender: when the slot is free, present the next matrix unless a random idle draw holds it back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (matrix_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
				s_tdata <= matrix_q[0];
				inverse_q.push_back(invert_matrix(matrix_q[0]));
				void'(matrix_q.pop_front());
				s_tvalid <= 1'b1;
				sent_cnt <= sent_cnt + 1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Long hold-off on the result side once the unthrottled phase starts.
	always @(posedge clk) begin
		if (!hold_done && sent_cnt >= 360) begin
			hold_done <= 1'b1;
			hold_cnt <= HOLD;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			int pct;
			pct = (sent_cnt < 175) ? 87 : (sent_cnt < 350) ? 29 : 0;
			m_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= pct);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			inverse_t want;
			bit bad;
			bad = 0;
			if (inverse_q.size() == 0) begin
				errors <= errors + 1;
				if (errors < 10)
					$display("ERROR: unexpected inverse word %h / %b", m_tdata, m_tuser);
			end else begin
				want = inverse_q.pop_front();
				for (int i = 0; i < NUM_ENT; i++)
					if (m_tdata[i*DW +: DW] !== want.entries[i*DW +: DW])
						bad = 1;
				if (m_tuser[USER_SINGULAR] !== want.flags[USER_SINGULAR])
					bad = 1;
				if (m_tuser[USER_SATURATED] !== want.flags[USER_SATURATED])
					bad = 1;
				if (bad) begin
					errors <= errors + 1;
					if (errors < 10) begin
						$display("ERROR: inverse mismatch");
						$display("  expected %h flags %b", want.entries, want.flags);
						$display("  actual   %h flags %b", m_tdata, m_tuser);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		// Identity, zero, and assorted edge matrices.
		matrix_q.push_back(pack_rows(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
		matrix_q.push_back(pack_rows(0, 0, 0, 0, 0, 0, 0, 0, 0));
		matrix_q.push_back(pack_rows(MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP));
		matrix_q.push_back(pack_rows(MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN));
		matrix_q.push_back(pack_rows(MAXP, 0, 0, 0, MAXP, 0, 0, 0, MAXP));
		matrix_q.push_back(pack_rows(MAXN, 0, 0, 0, MAXN, 0, 0, 0, MAXN));
		matrix_q.push_back(pack_rows(MAXN, 0, 0, 0, MAXP, 0, 0, 0, MAXN));
		matrix_q.push_back(pack_rows(1, 0, 0, 0, 1, 0, 0, 0, 1));
		matrix_q.push_back(pack_rows(-1, 0, 0, 0, 1, 0, 0, 0, -1));
		matrix_q.push_back(pack_rows(32'h0000_8000, 0, 0, 0, 32'h0000_8000, 0, 0, 0, ONE));
		matrix_q.push_back(pack_rows(32'h0002_0000, 0, 0, 0, -32'h0002_0000, 0, 0, 0, ONE));
		matrix_q.push_back(pack_rows(32'h0003_0000, 0, 0, 0, ONE, 0, 0, 0, ONE));
		matrix_q.push_back(pack_rows(32'h0002_0000, 0, 0, 0, 32'h0002_0000, 0, 0, 0,
			32'h0002_0000));
		matrix_q.push_back(pack_rows(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
		matrix_q.push_back(pack_rows(ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE));
		matrix_q.push_back(pack_rows(ONE, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
			32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0008_0000, 32'h000A_0000));
		matrix_q.push_back(pack_rows(ONE, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
			32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0008_0000, 32'h0009_0000));
		matrix_q.push_back(pack_rows(MAXP, MAXN, 1, -1, MAXP, 0, 0, MAXN, ONE));
		matrix_q.push_back(pack_rows(32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 32'h5555_5555,
			32'hAAAA_AAAA, 32'hAAAA_AAAA, 0, 32'h5555_5555));
		for (int i = 0; i < 431; i++)
			matrix_q.push_back(random_matrix());

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		wait (matrix_q.size() == 0 && inverse_q.size() == 0);
		repeat (3 * DW + 20) @(posedge clk);
		if (errors == 0 && inverse_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
